// ----- design/rvsc_pkg.sv -----
package rvsc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_FROST_TARGET = 3'd0;
  localparam logic [2:0] CFG_WARM_TARGET  = 3'd1;
  localparam logic [2:0] CFG_SETBACK      = 3'd2;
  localparam logic [2:0] CFG_BAKE_UPLIFT  = 3'd3;
  localparam logic [2:0] CFG_MIN_TARGET   = 3'd4;
  localparam logic [2:0] CFG_MAX_TARGET   = 3'd5;
  localparam logic [2:0] CFG_MAX_SLEW     = 3'd6;
  localparam logic [2:0] CFG_MIN_SLEW     = 3'd7;

  localparam logic [6:0] VALVE_MAX = 7'd100;
  localparam logic [4:0] FRAC_ONE  = 5'd16;
  localparam logic [2:0] AIM_STEP  = 3'd6;

  typedef struct packed {
    logic [6:0] frost_target_c;
    logic [6:0] warm_target_c;
    logic [4:0] setback_c;
    logic [4:0] bake_uplift_c;
    logic [6:0] target_floor;
    logic [6:0] target_ceiling;
    logic [6:0] max_slew_pc;
    logic [6:0] min_slew_pc;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] temp_sixteenths;
    logic               warm_mode;
    logic               bake_mode;
    logic               room_lit;
  } tick_t;

  typedef struct packed {
    logic [6:0] valve_percent;
    logic [6:0] target_temp_c;
    logic       valve_changed;
    logic       cancel_bake;
  } result_t;

endpackage

// ----- design/radiator_valve_slew_controller.sv -----
// Radiator valve slew controller. Each input transaction is one control tick
// carrying the room temperature in 1/16 degree C and the warm, bake and
// room-lit flags; each tick yields exactly one output transaction with the new
// valve opening, the target chosen, a changed flag and a bake-cancel flag.
// A tick is registered on entry, then the target choice and the valve update
// run in one stage into the result register; a new tick is taken every cycle
// unless a result held by out_ready low stalls the input: the valve opening
// feeds back from the result stage into the next tick's update. Configuration
// writes (eight registers, indexes 0..7) are always ready and should be made
// while no tick is in flight.
module radiator_valve_slew_controller (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  // tick input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [11:0] temp_sixteenths,
  input  logic               warm_mode,
  input  logic               bake_mode,
  input  logic               room_lit,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         valve_percent_out,
  output logic [6:0]         target_temp_c,
  output logic               valve_changed,
  output logic               cancel_bake
);

  rvsc_pkg::cfg_t    cfg;
  rvsc_pkg::tick_t   tick;
  rvsc_pkg::result_t result;

  logic       tick_valid;
  logic [6:0] valve_percent;
  logic [6:0] target_reg;
  logic       changed_reg;
  logic       cancel_reg;
  logic       out_load;
  logic       in_take;

  // the result stage loads when empty or when its transaction leaves
  assign out_load = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || out_load;
  assign in_take  = in_valid && in_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frost_target_c <= 7'd6;
      cfg.warm_target_c  <= 7'd18;
      cfg.setback_c      <= 5'd3;
      cfg.bake_uplift_c  <= 5'd10;
      cfg.target_floor   <= 7'd5;
      cfg.target_ceiling <= 7'd30;
      cfg.max_slew_pc    <= 7'd10;
      cfg.min_slew_pc    <= 7'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        rvsc_pkg::CFG_FROST_TARGET: cfg.frost_target_c <= cfg_data;
        rvsc_pkg::CFG_WARM_TARGET:  cfg.warm_target_c  <= cfg_data;
        rvsc_pkg::CFG_SETBACK:      cfg.setback_c      <= cfg_data[4:0];
        rvsc_pkg::CFG_BAKE_UPLIFT:  cfg.bake_uplift_c  <= cfg_data[4:0];
        rvsc_pkg::CFG_MIN_TARGET:   cfg.target_floor   <= cfg_data;
        rvsc_pkg::CFG_MAX_TARGET:   cfg.target_ceiling <= cfg_data;
        rvsc_pkg::CFG_MAX_SLEW:     cfg.max_slew_pc    <= cfg_data;
        rvsc_pkg::CFG_MIN_SLEW:     cfg.min_slew_pc    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick.temp_sixteenths <= temp_sixteenths;
      tick.warm_mode       <= warm_mode;
      tick.bake_mode       <= bake_mode;
      tick.room_lit        <= room_lit;
    end
  end

  rvsc_core u_core (
    .cfg       (cfg),
    .tick      (tick),
    .valve_old (valve_percent),
    .result    (result)
  );

  // result register; the valve opening doubles as controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      valve_percent <= '0;
    end else begin
      if (out_load) begin
        out_valid     <= 1'b1;
        valve_percent <= result.valve_percent;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      target_reg  <= result.target_temp_c;
      changed_reg <= result.valve_changed;
      cancel_reg  <= result.cancel_bake;
    end
  end

  assign valve_percent_out = valve_percent;
  assign target_temp_c     = target_reg;
  assign valve_changed     = changed_reg;
  assign cancel_bake       = cancel_reg;

endmodule

// ----- design/rvsc_core.sv -----
module rvsc_core (
  input  rvsc_pkg::cfg_t    cfg,
  input  rvsc_pkg::tick_t   tick,
  input  logic [6:0]        valve_old,
  output rvsc_pkg::result_t result
);

  logic [6:0]        warm_eff;
  logic [7:0]        bake_sum;
  logic [6:0]        bake_target;
  logic signed [7:0] dark_diff;
  logic [6:0]        dark_target;
  logic [6:0]        target;
  logic signed [8:0] whole;
  logic signed [8:0] target_s;
  logic [3:0]        frac;
  logic [4:0]        aim_units;
  logic [6:0]        aim;
  logic [7:0]        open_sum;
  logic [6:0]        err_dn;
  logic [6:0]        err_up;
  logic [6:0]        valve_new;
  logic              cancel;

  // target selection
  always_comb begin
    warm_eff = (cfg.warm_target_c < cfg.frost_target_c) ? cfg.frost_target_c
                                                        : cfg.warm_target_c;
    bake_sum = {1'b0, warm_eff} + {3'b000, cfg.bake_uplift_c};
    bake_target = (bake_sum > {1'b0, cfg.target_ceiling}) ? cfg.target_ceiling
                                                          : bake_sum[6:0];
    dark_diff = $signed({1'b0, warm_eff}) - $signed({3'b000, cfg.setback_c});
    dark_target = (dark_diff < $signed({1'b0, cfg.target_floor})) ? cfg.target_floor
                                                                   : dark_diff[6:0];
    if (!tick.warm_mode) begin
      target = cfg.frost_target_c;
    end else if (tick.bake_mode) begin
      target = bake_target;
    end else if (!tick.room_lit) begin
      target = dark_target;
    end else begin
      target = warm_eff;
    end
  end

  // valve movement
  always_comb begin
    whole     = {tick.temp_sixteenths[11], tick.temp_sixteenths[11:4]};
    target_s  = $signed({2'b00, target});
    frac      = tick.temp_sixteenths[3:0];
    aim_units = rvsc_pkg::FRAC_ONE - {1'b0, frac};
    aim       = {2'b00, aim_units} * {4'b0000, rvsc_pkg::AIM_STEP};
    open_sum  = {1'b0, valve_old} + {1'b0, cfg.max_slew_pc};
    err_dn    = valve_old - aim;
    err_up    = aim - valve_old;
    cancel    = 1'b0;
    valve_new = valve_old;
    if (whole < target_s) begin
      valve_new = (open_sum < {1'b0, rvsc_pkg::VALVE_MAX}) ? open_sum[6:0]
                                                           : rvsc_pkg::VALVE_MAX;
    end else if (whole > target_s) begin
      cancel    = 1'b1;
      valve_new = '0;
    end else if (aim < valve_old) begin
      if (err_dn >= cfg.min_slew_pc) begin
        valve_new = (err_dn > cfg.max_slew_pc) ? valve_old - cfg.max_slew_pc : aim;
      end
    end else if (aim > valve_old) begin
      if (err_up >= cfg.min_slew_pc) begin
        valve_new = (err_up > cfg.max_slew_pc) ? open_sum[6:0] : aim;
      end
    end
  end

  assign result.valve_percent = valve_new;
  assign result.target_temp_c = target;
  assign result.valve_changed = (valve_new != valve_old);
  assign result.cancel_bake   = cancel;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rvsc_pkg::*;

  // run limits in clock cycles, and the ticks sent per random register setting
  localparam int LIMIT_CYCLES  = 200000;
  localparam int DRAIN_CYCLES  = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_TICKS   = 85;

  // register values right after reset
  localparam cfg_t RESET_CFG = '{7'd6, 7'd18, 5'd3, 5'd10, 7'd5, 7'd30, 7'd10, 7'd7};

  typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  // dut inputs, all known from time zero
  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               cfg_valid       = 1'b0;
  logic [2:0]         cfg_index       = CFG_FROST_TARGET;
  logic [6:0]         cfg_data        = 7'd0;
  logic               in_valid        = 1'b0;
  logic signed [11:0] temp_sixteenths = 12'sd0;
  logic               warm_mode       = 1'b0;
  logic               bake_mode       = 1'b0;
  logic               room_lit        = 1'b0;
  logic               out_ready       = 1'b0;

  // dut outputs
  logic       cfg_ready;
  logic       in_ready;
  logic       out_valid;
  logic [6:0] valve_percent_out;
  logic [6:0] target_temp_c;
  logic       valve_changed;
  logic       cancel_bake;

  // shadow of the controller: its registers and the valve opening
  cfg_t       shadow_cfg   = RESET_CFG;
  logic [6:0] shadow_valve = 7'd0;

  // valve results still owed by the dut, oldest first
  result_t pending_valve_results[$];

  int errors             = 0;
  int ticks_sent         = 0;
  int results_checked    = 0;
  int settings_applied   = 0;
  int input_stall_cycles = 0;
  int cycle_count        = 0;
  int send_idle_pct      = 0;
  int recv_stall_pct     = 0;
  int hold_left          = 0;
  logic hold_go          = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radiator_valve_slew_controller i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .temp_sixteenths   (temp_sixteenths),
    .warm_mode         (warm_mode),
    .bake_mode         (bake_mode),
    .room_lit          (room_lit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .valve_percent_out (valve_percent_out),
    .target_temp_c     (target_temp_c),
    .valve_changed     (valve_changed),
    .cancel_bake       (cancel_bake)
  );

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // target choice from the current shadow registers; all in signed ints
  function automatic int choose_target(tick_t t);
    int frost, warm_eff, setback, uplift, floor_c, cap_c, tgt;
    frost    = int'(shadow_cfg.frost_target_c);
    warm_eff = int'(shadow_cfg.warm_target_c);
    setback  = int'(shadow_cfg.setback_c);
    uplift   = int'(shadow_cfg.bake_uplift_c);
    floor_c  = int'(shadow_cfg.target_floor);
    cap_c    = int'(shadow_cfg.target_ceiling);
    // comfort target is never below frost protection
    if (warm_eff < frost) warm_eff = frost;
    if (!t.warm_mode) begin
      tgt = frost;
    end else if (t.bake_mode) begin
      tgt = warm_eff + uplift;
      if (tgt > cap_c) tgt = cap_c;
    end else if (!t.room_lit) begin
      // signed, so a big setback cannot wrap below the floor
      tgt = warm_eff - setback;
      if (tgt < floor_c) tgt = floor_c;
    end else begin
      tgt = warm_eff;
    end
    return tgt;
  endfunction

  // next valve opening for one tick; advances the shadow valve
  function automatic result_t predict_valve(tick_t t);
    int whole, frac, tgt, old_v, v, aim, err, max_s, min_s;
    logic    cancel;
    result_t r;
    whole  = int'(t.temp_sixteenths);
    whole  = whole >>> 4;   // floor toward minus infinity
    frac   = int'(t.temp_sixteenths[3:0]);
    tgt    = choose_target(t);
    max_s  = int'(shadow_cfg.max_slew_pc);
    min_s  = int'(shadow_cfg.min_slew_pc);
    old_v  = int'(shadow_valve);
    v      = old_v;
    cancel = 1'b0;
    if (whole < tgt) begin
      // well below target: open by a full slew step
      v = (v + max_s < int'(VALVE_MAX)) ? v + max_s : int'(VALVE_MAX);
    end else if (whole > tgt) begin
      // above target: shut at once and drop any bake boost
      cancel = 1'b1;
      v      = 0;
    end else begin
      // inside the target degree: proportional aim, dead band of min slew
      aim = (int'(FRAC_ONE) - frac) * int'(AIM_STEP);
      if (aim < v) begin
        err = v - aim;
        if (err >= min_s) v = (err > max_s) ? v - max_s : aim;
      end else if (aim > v) begin
        err = aim - v;
        if (err >= min_s) v = (err > max_s) ? v + max_s : aim;
      end
    end
    shadow_valve    = v[6:0];
    r.valve_percent = v[6:0];
    r.target_temp_c = tgt[6:0];
    r.valve_changed = (v != old_v);
    r.cancel_bake   = cancel;
    return r;
  endfunction

  function automatic tick_t make_tick(int temp, bit warm, bit bake, bit lit);
    tick_t t;
    t.temp_sixteenths = temp[11:0];
    t.warm_mode       = warm;
    t.bake_mode       = bake;
    t.room_lit        = lit;
    return t;
  endfunction

  // mostly ticks around the target so the proportional path gets exercised
  function automatic tick_t random_tick();
    tick_t t;
    int    whole, temp;
    t = make_tick(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 75) begin
      whole = choose_target(t);
      if ($urandom_range(0, 99) < 50) whole += int'($urandom_range(0, 4)) - 2;
      temp = whole * 16 + int'($urandom_range(0, 15));
      if (temp > 2047) temp = 2047;
    end else begin
      temp = $urandom_range(0, 4095);
    end
    t.temp_sixteenths = temp[11:0];
    return t;
  endfunction

  // one register value: mostly in range, often at an end, sometimes any pattern
  function automatic logic [6:0] random_reg(int lo, int hi, int width);
    int pick, v;
    pick = $urandom_range(0, 99);
    if (pick < 10)      v = lo;
    else if (pick < 20) v = hi;
    else if (pick < 28) v = $urandom_range(0, (1 << width) - 1);
    else                v = $urandom_range(lo, hi);
    return v[6:0];
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.frost_target_c = random_reg(1, 100, 7);
    c.warm_target_c  = random_reg(1, 100, 7);
    c.setback_c      = 5'(random_reg(0, 31, 5));
    c.bake_uplift_c  = 5'(random_reg(0, 31, 5));
    c.target_floor   = random_reg(1, 100, 7);
    c.target_ceiling = random_reg(1, 100, 7);
    c.max_slew_pc    = random_reg(1, 100, 7);
    c.min_slew_pc    = random_reg(1, 100, 7);
    return c;
  endfunction

  task automatic set_pace(pace_t p);
    case (p)
      PACE_FREE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct  = 66;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  // wait until every owed result is in, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_valve_results.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (pending_valve_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived",
                                pending_valve_results.size()));
      pending_valve_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FROST_TARGET: shadow_cfg.frost_target_c = data;
      CFG_WARM_TARGET:  shadow_cfg.warm_target_c  = data;
      CFG_SETBACK:      shadow_cfg.setback_c      = data[4:0];
      CFG_BAKE_UPLIFT:  shadow_cfg.bake_uplift_c  = data[4:0];
      CFG_MIN_TARGET:   shadow_cfg.target_floor   = data;
      CFG_MAX_TARGET:   shadow_cfg.target_ceiling = data;
      CFG_MAX_SLEW:     shadow_cfg.max_slew_pc    = data;
      default:          shadow_cfg.min_slew_pc    = data;
    endcase
  endtask

  // writes all eight registers with the block idle; junk in the upper
  // bits of the 5-bit registers must be ignored
  task automatic apply_config(cfg_t c);
    drain_results();
    write_reg(CFG_FROST_TARGET, c.frost_target_c);
    write_reg(CFG_WARM_TARGET,  c.warm_target_c);
    write_reg(CFG_SETBACK,      {2'($urandom_range(0, 3)), c.setback_c});
    write_reg(CFG_BAKE_UPLIFT,  {2'($urandom_range(0, 3)), c.bake_uplift_c});
    write_reg(CFG_MIN_TARGET,   c.target_floor);
    write_reg(CFG_MAX_TARGET,   c.target_ceiling);
    write_reg(CFG_MAX_SLEW,     c.max_slew_pc);
    write_reg(CFG_MIN_SLEW,     c.min_slew_pc);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // offer one tick; valid is only lowered when the sender goes idle
  task automatic send_tick(tick_t t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    temp_sixteenths <= t.temp_sixteenths;
    warm_mode       <= t.warm_mode;
    bake_mode       <= t.bake_mode;
    room_lit        <= t.room_lit;
    do @(posedge clk); while (!in_ready);
    pending_valve_results.push_back(predict_valve(t));
    ticks_sent++;
  endtask

  // every mode with the reset registers, including negative temperatures
  task automatic test_modes_at_reset();
    set_pace(PACE_FREE);
    send_tick(make_tick(-2048, 0, 0, 1));      // far below frost target
    send_tick(make_tick(2047, 1, 1, 0));       // far above, cancels bake
    send_tick(make_tick(18 * 16, 1, 0, 1));    // in band, fraction zero
    send_tick(make_tick(18 * 16 + 15, 1, 0, 1)); // in band, error under min slew
    send_tick(make_tick(15 * 16 + 8, 1, 0, 0)); // dark room setback
    send_tick(make_tick(28 * 16 + 3, 1, 1, 1)); // bake uplift
    send_tick(make_tick(6 * 16 + 4, 0, 1, 0)); // frost mode ignores bake
    send_tick(make_tick(-1, 1, 0, 1));         // just below zero floors to -1
    send_tick(make_tick(31 * 16, 1, 1, 1));    // above bake target
    drain_results();
  endtask

  // clamps, floors and degenerate slew settings
  task automatic test_register_limits();
    set_pace(PACE_FREE);
    // warm below frost, setback past the floor, bake past the cap
    apply_config('{7'd9, 7'd3, 5'd31, 5'd31, 7'd5, 7'd20, 7'd100, 7'd100});
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(0, 1, 0, 0));          // already fully open
    send_tick(make_tick(20 * 16 + 8, 1, 1, 1));
    send_tick(make_tick(9 * 16, 1, 0, 1));
    send_tick(make_tick(21 * 16, 1, 1, 0));
    // zero slew can never move the valve below or inside the target degree
    apply_config('{7'd6, 7'd18, 5'd3, 5'd10, 7'd5, 7'd30, 7'd0, 7'd0});
    send_tick(make_tick(-2048, 1, 0, 1));
    send_tick(make_tick(18 * 16 + 8, 1, 0, 1));
    // every register at its top pattern
    apply_config('{7'd127, 7'd127, 5'd31, 5'd31, 7'd127, 7'd127, 7'd127, 7'd127});
    send_tick(make_tick(2047, 1, 1, 0));
    send_tick(make_tick(0, 1, 0, 0));
    // every register zero
    apply_config('{7'd0, 7'd0, 5'd0, 5'd0, 7'd0, 7'd0, 7'd0, 7'd0});
    send_tick(make_tick(0, 1, 0, 1));
    send_tick(make_tick(-2048, 0, 0, 0));
    send_tick(make_tick(16, 1, 1, 1));
    drain_results();
  endtask

  task automatic test_random_ticks(pace_t p);
    set_pace(p);
    repeat (2) begin
      apply_config(random_config());
      repeat (PHASE_TICKS) send_tick(random_tick());
    end
    drain_results();
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    set_pace(PACE_FREE);
    apply_config(random_config());
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (40) send_tick(random_tick());
    drain_results();
  endtask

  // receiver: random stalls, plus the long hold-off when requested
  always @(posedge clk) begin
    if (hold_go) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker: each output transaction against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_valve_results.size() == 0) begin
        report_mismatch("result with no tick waiting for it");
      end else begin
        want = pending_valve_results.pop_front();
        results_checked++;
        if (valve_percent_out !== want.valve_percent)
          report_mismatch($sformatf("valve_percent_out %0d, want %0d",
                                    valve_percent_out, want.valve_percent));
        if (target_temp_c !== want.target_temp_c)
          report_mismatch($sformatf("target_temp_c %0d, want %0d",
                                    target_temp_c, want.target_temp_c));
        if (valve_changed !== want.valve_changed)
          report_mismatch($sformatf("valve_changed %b, want %b",
                                    valve_changed, want.valve_changed));
        if (cancel_bake !== want.cancel_bake)
          report_mismatch($sformatf("cancel_bake %b, want %b",
                                    cancel_bake, want.cancel_bake));
      end
    end
  end

  // cycle count, input stall count and the watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stall_cycles++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_modes_at_reset();
    test_register_limits();
    test_random_ticks(PACE_FREE);
    test_random_ticks(PACE_SENDER_IDLE);
    test_random_ticks(PACE_RECEIVER_STALL);
    test_random_ticks(PACE_BOTH);
    test_output_backpressure();

    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_applied, results_checked);
    $display("%0d cycles with the input held off, %0d mismatches",
             input_stall_cycles, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
